### src/area_average_resampler_assert.svh
// Assertion macros for the area average resampler. Each one samples on the
// rising edge of i_clk, so a module that uses them must have that clock and
// the active-low reset i_rst_n in scope.
`ifndef AREA_AVERAGE_RESAMPLER_ASSERT_SVH
`define AREA_AVERAGE_RESAMPLER_ASSERT_SVH

`ifndef SYNTHESIS

// Checked only outside reset.
`define AAR_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("area_average_resampler assertion failed");

// Checked on every edge, reset included.
`define AAR_ASSERT_ALWAYS(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("area_average_resampler assertion failed");

`else

`define AAR_ASSERT(label, prop)
`define AAR_ASSERT_ALWAYS(label, prop)

`endif

`endif

### src/aar_pkg.sv
`default_nettype none

package aar_pkg;

    localparam int RateW      = 17;
    localparam int SmpW       = 16;
    localparam int SumW       = 34;
    localparam int MaxResults = 12;
    localparam int CntW       = $clog2(MaxResults + 1);
    localparam int FifoDepth  = 2;
    localparam int FifoAw     = $clog2(FifoDepth);
    localparam int FifoCntW   = $clog2(FifoDepth + 1);
    localparam int DivSteps   = RateW;
    localparam int DivCntW    = $clog2(DivSteps);
    localparam int CfgIdxW    = 1;

    localparam logic [RateW-1:0] SourceRateRst = 17'd44100;
    localparam logic [RateW-1:0] TargetRateRst = 17'd48000;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_IN_RATE     = 1'b0,
        CFG_TARGET_RATE = 1'b1
    } t_cfg_idx;

    // One classified input transaction as it waits in the queue.
    typedef struct packed {
        logic                   flush;
        logic signed [SmpW-1:0] mono;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    typedef struct packed {
        logic [RateW-1:0] in_rate;
        logic [RateW-1:0] target_rate;
        logic             clear;
    } t_rates;

    typedef struct packed {
        logic busy;
        logic div_busy;
    } t_back_stat;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL,
        BK_ACC,
        BK_DIV,
        BK_OUT
    } t_back_state;

endpackage

`default_nettype wire

### src/aar_front.sv
`default_nettype none

module aar_front (
    input  logic                           i_valid,
    input  logic                           i_mode,
    input  logic signed [aar_pkg::SmpW-1:0] i_left_sample,
    input  logic signed [aar_pkg::SmpW-1:0] i_right_sample,
    input  logic                           i_stereo,
    input  aar_pkg::t_q_stat               i_q_stat,
    output logic                           o_ready,
    output logic                           o_push,
    output aar_pkg::t_cmd                  o_cmd
);
    import aar_pkg::*;

    logic signed [SmpW:0] pair_sum;
    logic signed [SmpW:0] pair_bias;
    logic signed [SmpW-1:0] mono;

    // Stereo average truncates toward zero: bias a negative sum by one
    // before the arithmetic halving.
    always_comb begin
        pair_sum  = (SmpW+1)'(i_left_sample) + (SmpW+1)'(i_right_sample);
        pair_bias = pair_sum + $signed({{SmpW{1'b0}}, pair_sum[SmpW]});
        mono      = i_stereo ? pair_bias[SmpW:1] : i_left_sample;
    end

    assign o_ready    = !i_q_stat.full;
    assign o_push     = i_valid && !i_q_stat.full;
    assign o_cmd.flush = i_mode;
    assign o_cmd.mono  = mono;

endmodule

`default_nettype wire

### src/aar_fifo.sv
`default_nettype none

module aar_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  aar_pkg::t_cmd     i_data,
    input  logic              i_pop,
    output aar_pkg::t_cmd     o_data,
    output aar_pkg::t_q_stat  o_stat
);
    import aar_pkg::*;

    t_cmd                r_mem [FifoDepth];
    logic [FifoAw-1:0]   r_wr;
    logic [FifoAw-1:0]   r_rd;
    logic [FifoCntW-1:0] r_cnt;
    logic                do_push;
    logic                do_pop;

    assign o_stat.full  = (r_cnt == FifoCntW'(FifoDepth));
    assign o_stat.empty = (r_cnt == '0);
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;
    assign o_data       = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == FifoAw'(FifoDepth - 1)) ? '0 : r_wr + 1'b1;
            end
            if (do_pop) begin
                r_rd <= (r_rd == FifoAw'(FifoDepth - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + FifoCntW'(do_push) - FifoCntW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

### src/aar_div.sv
`default_nettype none

module aar_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic signed [aar_pkg::SumW-1:0]  i_dividend,
    input  logic [aar_pkg::RateW-1:0]        i_divisor,
    output aar_pkg::t_div_stat               o_stat,
    output logic signed [aar_pkg::SmpW-1:0]  o_quot
);
    import aar_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [DivCntW-1:0]  r_cnt;
    logic [RateW-1:0]    r_rem;
    logic [RateW-1:0]    r_q;
    logic [RateW-1:0]    r_dvs;
    logic                r_neg;

    logic [SumW-1:0]     mag;
    logic [RateW:0]      rem_sh;
    logic [RateW:0]      diff;
    logic                ge;

    // The dividend is an average times its weight, so the magnitude of the
    // quotient stays below 2^17 and only the low 17 quotient bits are worked.
    always_comb begin
        mag    = i_dividend[SumW-1] ? SumW'(-i_dividend) : SumW'(i_dividend);
        rem_sh = {r_rem, r_q[RateW-1]};
        diff   = rem_sh - {1'b0, r_dvs};
        ge     = (rem_sh >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DivCntW'(DivSteps - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[SumW-1];
            r_dvs <= i_divisor;
            r_rem <= mag[SumW-1:RateW];
            r_q   <= mag[RateW-1:0];
        end else if (r_busy) begin
            r_rem <= ge ? diff[RateW-1:0] : rem_sh[RateW-1:0];
            r_q   <= {r_q[RateW-2:0], ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quot      = r_neg ? -$signed(r_q[SmpW-1:0]) : $signed(r_q[SmpW-1:0]);

endmodule

`default_nettype wire

### src/aar_back.sv
`default_nettype none

module aar_back (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  aar_pkg::t_rates                  i_rates,
    input  aar_pkg::t_q_stat                 i_q_stat,
    input  aar_pkg::t_cmd                    i_cmd,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [aar_pkg::SmpW-1:0]  o_out_sample,
    output logic                             o_last,
    output aar_pkg::t_back_stat              o_stat
);
    import aar_pkg::*;

    t_back_state            r_state, n_state;
    logic signed [SumW-1:0] r_sum, n_sum;
    logic [RateW-1:0]       r_fill, n_fill;
    logic [RateW-1:0]       r_rem, n_rem;
    logic signed [SmpW-1:0] r_mono, n_mono;
    logic [RateW-1:0]       r_w, n_w;
    logic signed [SumW-1:0] r_prod, n_prod;
    logic [CntW-1:0]        r_cnt, n_cnt;
    logic                   r_last_pend, n_last_pend;
    logic                   r_out_valid, n_out_valid;
    logic signed [SmpW-1:0] r_out_sample, n_out_sample;
    logic                   r_out_last, n_out_last;

    logic [RateW-1:0]       room;
    logic [RateW-1:0]       w;
    logic signed [RateW:0]  w_s;
    logic signed [SumW-1:0] sum_acc;
    logic [RateW-1:0]       fill_acc;
    logic [RateW-1:0]       rem_acc;

    logic                   div_start;
    logic signed [SumW-1:0] div_dividend;
    logic [RateW-1:0]       div_divisor;
    t_div_stat              div_stat;
    logic signed [SmpW-1:0] div_quot;

    aar_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_stat     (div_stat),
        .o_quot     (div_quot)
    );

    always_comb begin
        room     = i_rates.in_rate - r_fill;
        w        = (r_rem < room) ? r_rem : room;
        w_s      = $signed({1'b0, w});
        sum_acc  = r_sum + r_prod;
        fill_acc = r_fill + r_w;
        rem_acc  = r_rem - r_w;
    end

    always_comb begin
        n_state      = r_state;
        n_sum        = r_sum;
        n_fill       = r_fill;
        n_rem        = r_rem;
        n_mono       = r_mono;
        n_w          = r_w;
        n_prod       = r_prod;
        n_cnt        = r_cnt;
        n_last_pend  = r_last_pend;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_sample = r_out_sample;
        n_out_last   = r_out_last;
        o_pop        = 1'b0;
        div_start    = 1'b0;
        div_dividend = r_sum;
        div_divisor  = i_rates.in_rate;

        case (r_state)
            BK_IDLE: begin
                if (!i_q_stat.empty) begin
                    o_pop = 1'b1;
                    if (i_cmd.flush) begin
                        if (r_fill != '0) begin
                            div_start   = 1'b1;
                            div_divisor = r_fill;
                            n_last_pend = 1'b1;
                            n_rem       = '0;
                            n_state     = BK_DIV;
                        end
                        n_sum  = '0;
                        n_fill = '0;
                    end else if (i_rates.in_rate != '0 &&
                                 i_rates.target_rate != '0) begin
                        n_mono  = i_cmd.mono;
                        n_rem   = i_rates.target_rate;
                        n_cnt   = '0;
                        n_state = BK_MUL;
                    end
                end
            end
            BK_MUL: begin
                n_w     = w;
                n_prod  = r_mono * w_s;
                n_state = BK_ACC;
            end
            BK_ACC: begin
                if (fill_acc == i_rates.in_rate) begin
                    div_start    = 1'b1;
                    div_dividend = sum_acc;
                    n_sum        = '0;
                    n_fill       = '0;
                    n_rem        = rem_acc;
                    n_cnt        = r_cnt + 1'b1;
                    // Another bin follows only if the leftover weight fills a
                    // whole bin and the per-transaction cap is not reached.
                    n_last_pend  = (r_cnt == CntW'(MaxResults - 1)) ||
                                   (rem_acc < i_rates.in_rate);
                    n_state      = BK_DIV;
                end else begin
                    n_sum   = sum_acc;
                    n_fill  = fill_acc;
                    n_rem   = rem_acc;
                    n_state = BK_IDLE;
                end
            end
            BK_DIV: begin
                if (div_stat.done) begin
                    n_state = BK_OUT;
                end
            end
            BK_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid  = 1'b1;
                    n_out_sample = div_quot;
                    n_out_last   = r_last_pend;
                    n_state      = (r_rem != '0 && r_cnt != CntW'(MaxResults)) ?
                                   BK_MUL : BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase

        if (i_rates.clear) begin
            n_sum  = '0;
            n_fill = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_sum       <= '0;
            r_fill      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sum       <= n_sum;
            r_fill      <= n_fill;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_mono       <= n_mono;
        r_w          <= n_w;
        r_prod       <= n_prod;
        r_cnt        <= n_cnt;
        r_last_pend  <= n_last_pend;
        r_out_sample <= n_out_sample;
        r_out_last   <= n_out_last;
    end

    assign o_valid         = r_out_valid;
    assign o_out_sample    = r_out_sample;
    assign o_last          = r_out_last;
    assign o_stat.busy     = (r_state != BK_IDLE);
    assign o_stat.div_busy = div_stat.busy;

endmodule

`default_nettype wire

### src/area_average_resampler.sv
// A sample that closes no bin is absorbed by a multiply and an accumulate pass;
// one that closes a bin then runs the 17-step divider before its first result is
// presented, and a flush of a filled bin runs the divider alone before its result.
// The back end works on one transaction at a time and stalls while a finished result
// waits for i_ready; the queue keeps accepting new transactions until it is full.
// Reset (synchronous, active low) clears queue, bin and output; rates load 44100/48000.
`default_nettype none

module area_average_resampler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration write port.
    input  logic                                i_cfg_we,
    input  logic [aar_pkg::CfgIdxW-1:0]         i_cfg_index,
    input  logic [aar_pkg::RateW-1:0]           i_cfg_data,
    // Input channel.
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_mode,
    input  logic signed [aar_pkg::SmpW-1:0]     i_left_sample,
    input  logic signed [aar_pkg::SmpW-1:0]     i_right_sample,
    input  logic                                i_stereo,
    // Output channel.
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [aar_pkg::SmpW-1:0]     o_out_sample,
    output logic                                o_last
);
    import aar_pkg::*;

    // The front end classifies each input transaction (flush or audio) and
    // folds a stereo pair into one mono value. The result waits in a short
    // queue, so the input side keeps accepting while the back end works, until it fills.
    // The back end pours the sample's weight into bins, one multiply and one
    // accumulate per pass, and runs the shared divider for every full or flushed bin.

    logic [RateW-1:0] r_in_rate;
    logic [RateW-1:0] r_target_rate;
    t_rates           rates;
    t_q_stat          q_stat;
    t_cmd             push_cmd;
    t_cmd             head_cmd;
    logic             push;
    logic             pop;
    t_back_stat       bk_stat;

    // Configuration registers. Any write also empties the current bin,
    // which the back end sees through the clear flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_rate     <= SourceRateRst;
            r_target_rate <= TargetRateRst;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IN_RATE:     r_in_rate     <= i_cfg_data;
                CFG_TARGET_RATE: r_target_rate <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign rates.in_rate     = r_in_rate;
    assign rates.target_rate = r_target_rate;
    assign rates.clear       = i_cfg_we;

    aar_front u_front (
        .i_valid        (i_valid),
        .i_mode         (i_mode),
        .i_left_sample  (i_left_sample),
        .i_right_sample (i_right_sample),
        .i_stereo       (i_stereo),
        .i_q_stat       (q_stat),
        .o_ready        (o_ready),
        .o_push         (push),
        .o_cmd          (push_cmd)
    );

    aar_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_cmd),
        .i_pop   (pop),
        .o_data  (head_cmd),
        .o_stat  (q_stat)
    );

    // The back end owns the bin accumulator and the output register; a
    // finished result waits there while the queue keeps filling.
    aar_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_rates      (rates),
        .i_q_stat     (q_stat),
        .i_cmd        (head_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_out_sample (o_out_sample),
        .o_last       (o_last),
        .o_stat       (bk_stat)
    );

`include "area_average_resampler_assert.svh"

    // Reset leaves no result pending and the back end idle.
    `AAR_ASSERT_ALWAYS(a_reset_quiet, !i_rst_n |=> !o_valid && !bk_stat.busy)

    // An accepted transaction is in the queue on the following edge.
    `AAR_ASSERT(a_accept_queued, i_valid && o_ready |=> !q_stat.empty)

    // A result only appears out of work the back end was doing.
    `AAR_ASSERT(a_result_from_work, $rose(o_valid) |-> $past(bk_stat.busy))

    // The divider only runs on behalf of a transaction in progress.
    `AAR_ASSERT(a_div_owned, bk_stat.div_busy |-> bk_stat.busy)

endmodule

`default_nettype wire

### test/resampler_checker.sv
`default_nettype none

module resampler_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [aar_pkg::CfgIdxW-1:0]     i_cfg_index,
    input  logic [aar_pkg::RateW-1:0]       i_cfg_data,
    input  logic                            i_in_valid,
    input  logic                            i_in_ready,
    input  logic                            i_mode,
    input  logic signed [aar_pkg::SmpW-1:0] i_left_sample,
    input  logic signed [aar_pkg::SmpW-1:0] i_right_sample,
    input  logic                            i_stereo,
    input  logic                            i_out_valid,
    input  logic                            i_out_ready,
    input  logic signed [aar_pkg::SmpW-1:0] i_out_sample,
    input  logic                            i_last,
    output int                              o_fail_count,
    output int                              o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import aar_pkg::*;

    typedef struct packed {
        logic signed [SmpW-1:0] sample;
        logic                   last;
    } t_pcm_out;

    t_pcm_out         expected_pcm[$];
    logic [RateW-1:0] bin_width;
    logic [RateW-1:0] sample_weight;
    longint           bin_acc;
    int               bin_fill;
    int               mismatches = 0;

    // Pours one input transaction into the bins and queues every bin it closes.
    function automatic void pour_into_bins(logic flush_req, logic signed [SmpW-1:0] left,
                                           logic signed [SmpW-1:0] right, logic pair);
        logic signed [SmpW-1:0] avg [MaxResults];
        int       mono;
        int       remaining;
        int       room;
        int       w;
        int       n;
        t_pcm_out rec;
        n = 0;
        if (flush_req) begin
            if (bin_fill != 0) begin
                avg[0] = SmpW'(bin_acc / longint'(bin_fill));
                n = 1;
            end
            bin_acc  = 0;
            bin_fill = 0;
        end else if (bin_width != '0) begin
            mono = left;
            if (pair) begin
                mono = (int'(left) + int'(right)) / 2;
            end
            remaining = int'(sample_weight);
            while (remaining != 0 && n < MaxResults) begin
                room = int'(bin_width) - bin_fill;
                w = (remaining < room) ? remaining : room;
                bin_acc   += longint'(mono) * longint'(w);
                bin_fill  += w;
                remaining -= w;
                if (bin_fill == int'(bin_width)) begin
                    avg[n] = SmpW'(bin_acc / longint'(bin_width));
                    n++;
                    bin_acc  = 0;
                    bin_fill = 0;
                end
            end
        end
        for (int k = 0; k < n; k++) begin
            rec.sample = avg[k];
            rec.last   = (k == n - 1);
            expected_pcm.push_back(rec);
        end
    endfunction

    always @(posedge i_clk) begin : watch
        t_pcm_out due;
        if (!i_rst_n) begin
            bin_width     = SourceRateRst;
            sample_weight = TargetRateRst;
            bin_acc       = 0;
            bin_fill      = 0;
            expected_pcm.delete();
        end else begin
            // Results are checked before this edge's input is predicted, so a
            // result can never be matched against its own cause.
            if (i_out_valid && i_out_ready) begin
                if (expected_pcm.size() == 0) begin
                    $error("out_sample: expected nothing, actual %0d", i_out_sample);
                    mismatches++;
                end else begin
                    due = expected_pcm.pop_front();
                    if (due.sample !== i_out_sample) begin
                        $error("out_sample: expected %0d, actual %0d",
                               $signed(due.sample), i_out_sample);
                        mismatches++;
                    end
                    if (due.last !== i_last) begin
                        $error("last: expected %0b, actual %0b", due.last, i_last);
                        mismatches++;
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_IN_RATE:     bin_width     = i_cfg_data;
                    CFG_TARGET_RATE: sample_weight = i_cfg_data;
                    default: ;
                endcase
                bin_acc  = 0;
                bin_fill = 0;
            end
            if (i_in_valid && i_in_ready) begin
                pour_into_bins(i_mode, i_left_sample, i_right_sample, i_stereo);
            end
        end
        o_pending    <= expected_pcm.size();
        o_fail_count <= mismatches;
    end

endmodule

`default_nettype wire

### test/tb_top.sv
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import aar_pkg::*;

    localparam int ResetCycles  = 5;
    localparam int SettleCycles = 40;   // lets a non-emitting sample be absorbed
    localparam int LongHold     = 300;  // receiver hold-off that backs the block up
    localparam int TailCycles   = 60;
    localparam int NumPhases    = 9;
    localparam logic [RateW-1:0] RateAllOnes = '1;

    logic                   clk            = 1'b0;
    logic                   rst_n          = 1'b0;
    logic                   cfg_we         = 1'b0;
    t_cfg_idx               cfg_index      = CFG_IN_RATE;
    logic [RateW-1:0]       cfg_data       = '0;
    logic                   in_valid       = 1'b0;
    logic                   in_ready;
    logic                   mode           = 1'b0;
    logic signed [SmpW-1:0] left_sample    = '0;
    logic signed [SmpW-1:0] right_sample   = '0;
    logic                   stereo         = 1'b0;
    logic                   out_valid;
    logic                   out_ready      = 1'b0;
    logic signed [SmpW-1:0] out_sample;
    logic                   out_last;
    int                     fail_count;
    int                     pending;

    // Handshake between the stimulus and the receiver: when set, the receiver
    // takes the request, clears it and runs the LongHold hold-off.
    bit hold_req = 1'b0;
    // While set, the sender offers transactions back to back.
    bit tx_calm  = 1'b0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    area_average_resampler DUT (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_valid        (in_valid),
        .o_ready        (in_ready),
        .i_mode         (mode),
        .i_left_sample  (left_sample),
        .i_right_sample (right_sample),
        .i_stereo       (stereo),
        .o_valid        (out_valid),
        .i_ready        (out_ready),
        .o_out_sample   (out_sample),
        .o_last         (out_last)
    );

    resampler_checker u_checker (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .i_in_valid     (in_valid),
        .i_in_ready     (in_ready),
        .i_mode         (mode),
        .i_left_sample  (left_sample),
        .i_right_sample (right_sample),
        .i_stereo       (stereo),
        .i_out_valid    (out_valid),
        .i_out_ready    (out_ready),
        .i_out_sample   (out_sample),
        .i_last         (out_last),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    // Idle lengths: mostly none or a few cycles, now and then a long one.
    function automatic int idle_gap(bit calm);
        int r;
        if (calm) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55) begin
            return 0;
        end else if (r < 85) begin
            return $urandom_range(1, 3);
        end else if (r < 96) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // PCM values with extra weight on full scale and on tiny values around
    // zero, where truncation toward zero shows up.
    function automatic logic signed [SmpW-1:0] rand_pcm();
        int r;
        r = $urandom_range(0, 15);
        case (r)
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return SmpW'($urandom_range(0, 6) - 3);
            default: return SmpW'($urandom);
        endcase
    endfunction

    // Offers one transaction and returns at the edge that accepted it. The
    // caller is always at a rising edge, so valid stays high between
    // back-to-back transactions without being lowered in the same step.
    task automatic offer(logic m, logic signed [SmpW-1:0] l, logic signed [SmpW-1:0] r,
                         logic st);
        int gap;
        gap = idle_gap(tx_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        mode         <= m;
        left_sample  <= l;
        right_sample <= r;
        stereo       <= st;
        // The ready output only moves on a rising edge, so it is stable here.
        @(negedge clk);
        while (!in_ready) @(negedge clk);
        @(posedge clk);
    endtask

    task automatic offer_random();
        logic m;
        m = ($urandom_range(0, 19) == 0);
        offer(m, rand_pcm(), rand_pcm(), 1'($urandom_range(0, 1)));
    endtask

    // Stops offering, waits until every predicted result has been taken and
    // then lets a sample that closes no bin finish inside the block.
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        repeat (SettleCycles) @(posedge clk);
    endtask

    task automatic write_rates(bit set_src, logic [RateW-1:0] src, bit set_tgt,
                               logic [RateW-1:0] tgt);
        if (set_src) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IN_RATE;
            cfg_data  <= src;
            @(posedge clk);
        end
        if (set_tgt) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_TARGET_RATE;
            cfg_data  <= tgt;
            @(posedge clk);
        end
        cfg_we <= 1'b0;
    endtask

    // Receiver: takes results with random hold-offs, runs of steady readiness,
    // and one long hold-off when the stimulus asks for it.
    initial begin : receiver
        int  gap;
        bit  calm;
        calm = 1'b0;
        @(negedge clk);
        while (!rst_n) @(negedge clk);
        @(posedge clk);
        forever begin
            if ($urandom_range(0, 15) == 0) begin
                calm = !calm;
            end
            if (hold_req) begin
                gap      = LongHold;
                hold_req = 1'b0;
            end else begin
                gap = idle_gap(calm);
            end
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    initial begin : stimulus
        logic [RateW-1:0] src;
        logic [RateW-1:0] tgt;
        bit               set_src;
        bit               set_tgt;
        int               items;

        repeat (ResetCycles) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, at the reset rates (44100 in, 48000 out).
        // A flush straight after reset finds an empty bin and emits nothing.
        offer(1'b1, 16'sh1234, 16'sh4321, 1'b0);
        offer(1'b0, 16'sh7FFF, 16'sh0000, 1'b0);
        offer(1'b0, 16'sh8000, 16'sh7FFF, 1'b0);
        offer(1'b0, 16'sh7FFF, 16'sh7FFF, 1'b1);
        offer(1'b0, 16'sh8000, 16'sh8000, 1'b1);
        // Pair averages of -1/2 and -3/2 truncate toward zero.
        offer(1'b0, 16'sh8000, 16'sh7FFF, 1'b1);
        offer(1'b0, -16'sd3, 16'sd0, 1'b1);
        offer(1'b0, 16'sd5, -16'sd1, 1'b0);
        // Partial bin flush divides by the fill; the second one is empty again.
        offer(1'b1, 16'sh0000, 16'sh0000, 1'b0);
        offer(1'b1, 16'shFFFF, 16'shFFFF, 1'b1);
        drain();

        // Bins one unit wide with the largest weight: the result cap drops the
        // rest of each sample, so the following flush finds nothing.
        write_rates(1'b1, 17'd1, 1'b1, RateAllOnes);
        offer(1'b0, 16'sd100, 16'sd0, 1'b0);
        offer(1'b0, 16'sh8000, 16'sh7FFF, 1'b1);
        offer(1'b1, 16'sd0, 16'sd0, 1'b0);
        drain();

        // Zero bin width: samples are ignored.
        write_rates(1'b1, '0, 1'b0, '0);
        offer(1'b0, 16'sh7FFF, 16'sd0, 1'b0);
        offer(1'b0, 16'sh8000, 16'sh8000, 1'b1);
        offer(1'b1, 16'sd0, 16'sd0, 1'b0);
        drain();

        // Zero weight: samples change nothing.
        write_rates(1'b1, RateAllOnes, 1'b1, '0);
        offer(1'b0, 16'sh7FFF, 16'sd0, 1'b0);
        offer(1'b0, 16'sh8000, 16'sh7FFF, 1'b1);
        offer(1'b1, 16'sd0, 16'sd0, 1'b0);
        drain();

        // The widest bin with the smallest weight only ever fills through a flush.
        write_rates(1'b0, '0, 1'b1, 17'd1);
        offer(1'b0, 16'sh7FFF, 16'sd0, 1'b0);
        offer(1'b0, 16'sh8000, 16'sh8000, 1'b1);
        offer(1'b1, 16'sd0, 16'sd0, 1'b0);
        drain();

        // Random part, one rate setting per phase.
        for (int ph = 0; ph < NumPhases; ph++) begin
            set_src = 1'b1;
            set_tgt = 1'b1;
            items   = 33;
            case (ph)
                0: begin src = 17'd44100; tgt = 17'd48000; end
                1: begin src = 17'd48000; tgt = 17'd44100; end
                2: begin src = 17'd8000;  tgt = 17'd96000; items = 16; end
                3: begin src = 17'd96000; tgt = 17'd8000;  end
                4: begin src = 17'd32000; tgt = 17'd32000; end
                5: begin
                    src = 17'($urandom_range(8000, 96000));
                    tgt = 17'($urandom_range(1, 96000));
                end
                6: begin
                    // Only the weight changes; the bin width stays from before.
                    set_src = 1'b0;
                    src     = '0;
                    tgt     = 17'($urandom_range(1, 96000));
                end
                7: begin src = 17'd96000; tgt = 17'd1; end
                default: begin
                    src = 17'($urandom_range(1, 131071));
                    tgt = 17'($urandom_range(0, 131071));
                    if (tgt > src * 12) begin
                        items = 12;
                    end
                end
            endcase
            write_rates(set_src, src, set_tgt, tgt);

            // The first phase keeps offering while the receiver holds off, so
            // the queue inside the block fills and its ready drops.
            if (ph == 0) begin
                tx_calm  = 1'b1;
                hold_req = 1'b1;
            end
            for (int i = 0; i < items; i++) begin
                if (ph != 0 && $urandom_range(0, 11) == 0) begin
                    tx_calm = !tx_calm;
                end
                offer_random();
            end
            if ($urandom_range(0, 1) == 1) begin
                offer(1'b1, rand_pcm(), rand_pcm(), 1'b0);
            end
            tx_calm = 1'b0;
            // The sender pauses here until every predicted result is out.
            drain();
        end

        repeat (TailCycles) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("SUCCESS");
        end else begin
            if (pending != 0) begin
                $error("out_sample: %0d results still expected", pending);
            end
            $display("FAILURE");
        end
        $finish;
    end

    // Run limit, far above the slowest correct run.
    initial begin : watchdog
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
